### hw/rtl/ppmfr_pkg.sv
// Shared types and constants for the parabolic face reconstruction block.
// Used by ppmfr_div and ppm_face_reconstruct_top; no dependencies.
`default_nettype none

package ppmfr_pkg;

  localparam int DW  = 32;  // Q16.16 field width
  localparam int QW  = 35;  // van Leer quotient width, one bit per divider stage
  localparam int SW  = 38;  // slope width, Q.17
  localparam int FW  = 48;  // face width, units of 2^-16/12

  localparam logic [19:0] RECIP3 = 20'd699051;  // ceil(2^21 / 3)

  typedef enum logic [1:0] {
    LIM_VANLEER = 2'd0,
    LIM_MC      = 2'd1,
    LIM_MINMOD  = 2'd2,
    LIM_NONE    = 2'd3
  } lim_mode_t;

  typedef struct packed {
    logic [2:0][SW-1:0] alt;
    logic [2:0]         van;
    logic [2:0]         neg;
    logic [DW-1:0]      y1;
    logic [DW-1:0]      y2;
    logic [DW-1:0]      y3;
  } side_t;

endpackage

`default_nettype wire

### hw/rtl/ppmfr_div.sv
// Pipelined restoring divider: floor(8 * num / den), one quotient bit per stage.
// Depends on ppmfr_pkg.
`default_nettype none

module ppmfr_div (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [63:0]               num,
  input  wire logic [32:0]               den,
  output      logic [ppmfr_pkg::QW-1:0]  quo
);
  import ppmfr_pkg::*;

  logic [QW:0][32:0]   rem_w;
  logic [QW:0][QW-1:0] low_w;
  logic [QW:0][QW-1:0] quo_w;
  logic [QW:0][32:0]   den_w;

  assign rem_w[0] = {1'b0, num[63:32]};
  assign low_w[0] = {num[31:0], 3'b000};
  assign quo_w[0] = '0;
  assign den_w[0] = den;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [33:0] trial;
    logic [33:0] diff;
    logic        ge;
    logic [32:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] qv;
    logic [32:0] dv;

    assign trial = {rem_w[i], low_w[i][QW-1]};
    assign diff  = trial - {1'b0, den_w[i]};
    assign ge    = trial >= {1'b0, den_w[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem <= ge ? diff[32:0] : trial[32:0];
        low <= {low_w[i][QW-2:0], 1'b0};
        qv  <= {quo_w[i][QW-2:0], ge};
        dv  <= den_w[i];
      end
    end

    assign rem_w[i+1] = rem;
    assign low_w[i+1] = low;
    assign quo_w[i+1] = qv;
    assign den_w[i+1] = dv;
  end

  assign quo = quo_w[QW];

endmodule

`default_nettype wire

### hw/rtl/ppm_face_reconstruct_top.sv
// One item per cycle while no result waits at the output.
// The 35-stage van Leer divider sets the depth; all stages advance together
// and hold while a result waits at the output.
// Reset clears the valid bits and sets limiter_mode to monotonized central.
// Depends on ppmfr_pkg and ppmfr_div.
`default_nettype none

module ppm_face_reconstruct_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [1:0]                   cfg_data,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic signed [ppmfr_pkg::DW-1:0] zone_minus2,
  input  wire logic signed [ppmfr_pkg::DW-1:0] zone_minus1,
  input  wire logic signed [ppmfr_pkg::DW-1:0] zone_centre,
  input  wire logic signed [ppmfr_pkg::DW-1:0] zone_plus1,
  input  wire logic signed [ppmfr_pkg::DW-1:0] zone_plus2,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic signed [ppmfr_pkg::DW-1:0] left_face,
  output      logic signed [ppmfr_pkg::DW-1:0] right_face
);
  import ppmfr_pkg::*;

  localparam int NST = 3 + QW + 7;

  logic            adv;
  lim_mode_t       mode;
  logic [NST-1:0]  vp;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= LIM_MC;
      vp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode <= lim_mode_t'(cfg_data);
      end
      if (adv) begin
        vp        <= {vp[NST-2:0], in_valid};
        out_valid <= vp[NST-1];
      end
    end
  end

  // s1: capture
  logic signed [DW-1:0] s1_y [5];
  lim_mode_t            s1_mode;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_y[0] <= zone_minus2;
      s1_y[1] <= zone_minus1;
      s1_y[2] <= zone_centre;
      s1_y[3] <= zone_plus1;
      s1_y[4] <= zone_plus2;
      s1_mode <= mode;
    end
  end

  // s2: differences
  logic [DW-1:0]        s2_ae [4];
  logic signed [DW:0]   s2_dc [3];
  logic [2:0]           s2_same;
  logic signed [DW-1:0] s2_y1, s2_y2, s2_y3;
  lim_mode_t            s2_mode;

  logic [DW-1:0]        ae_c [4];
  logic signed [DW:0]   e_c  [4];
  logic signed [DW:0]   dc_c [3];
  logic [2:0]           same_c;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      e_c[k]  = (DW+1)'(s1_y[k+1]) - (DW+1)'(s1_y[k]);
      ae_c[k] = e_c[k][DW] ? DW'(-e_c[k]) : e_c[k][DW-1:0];
    end
    for (int k = 0; k < 3; k++) begin
      dc_c[k]   = (DW+1)'(s1_y[k+2]) - (DW+1)'(s1_y[k]);
      same_c[k] = (e_c[k] > 0 && e_c[k+1] > 0) || (e_c[k] < 0 && e_c[k+1] < 0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ae   <= ae_c;
      s2_dc   <= dc_c;
      s2_same <= same_c;
      s2_y1   <= s1_y[1];
      s2_y2   <= s1_y[2];
      s2_y3   <= s1_y[3];
      s2_mode <= s1_mode;
    end
  end

  // s3: products, sums, non-divider slopes
  logic [63:0] s3_p [3];
  logic [32:0] s3_s [3];
  side_t       s3_side;

  logic [63:0] p_c [3];
  logic [32:0] s_c [3];
  side_t       side_c;

  always_comb begin
    logic [33:0] m1, m2, adc, mmin, mmc, mag;
    logic signed [SW-1:0] sl;
    side_c    = '0;
    side_c.y1 = s2_y1;
    side_c.y2 = s2_y2;
    side_c.y3 = s2_y3;
    for (int k = 0; k < 3; k++) begin
      p_c[k] = 64'(s2_ae[k]) * 64'(s2_ae[k+1]);
      s_c[k] = {1'b0, s2_ae[k]} + {1'b0, s2_ae[k+1]};
      m1   = {s2_ae[k], 2'b00};
      m2   = {s2_ae[k+1], 2'b00};
      adc  = s2_dc[k][DW] ? 34'(-s2_dc[k]) : 34'(s2_dc[k][DW-1:0]);
      mmin = (m1 < m2) ? m1 : m2;
      mmc  = (adc < mmin) ? adc : mmin;
      case (s2_mode)
        LIM_MC:     mag = mmc;
        LIM_MINMOD: mag = mmin;
        default:    mag = '0;
      endcase
      if (s2_mode == LIM_NONE) begin
        sl = SW'(s2_dc[k]);
      end else if (!s2_same[k]) begin
        sl = '0;
      end else if (s2_dc[k][DW]) begin
        sl = -$signed(SW'(mag));
      end else begin
        sl = $signed(SW'(mag));
      end
      side_c.alt[k] = sl;
      side_c.van[k] = (s2_mode == LIM_VANLEER) && s2_same[k];
      side_c.neg[k] = s2_dc[k][DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_p    <= p_c;
      s3_s    <= s_c;
      s3_side <= side_c;
    end
  end

  // divider lanes and matching side delay
  logic [QW-1:0] quo [3];
  side_t         side_q [QW];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    ppmfr_div u_div (
      .clk (clk),
      .en  (adv),
      .num (s3_p[k]),
      .den (s3_s[k]),
      .quo (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= s3_side;
      for (int i = 1; i < QW; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // f1: final slopes
  logic signed [SW-1:0] f1_sl [3];
  logic signed [DW-1:0] f1_y1, f1_y2, f1_y3;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        if (side_q[QW-1].van[k]) begin
          f1_sl[k] <= side_q[QW-1].neg[k] ? -$signed(SW'(quo[k])) : $signed(SW'(quo[k]));
        end else begin
          f1_sl[k] <= $signed(side_q[QW-1].alt[k]);
        end
      end
      f1_y1 <= $signed(side_q[QW-1].y1);
      f1_y2 <= $signed(side_q[QW-1].y2);
      f1_y3 <= $signed(side_q[QW-1].y3);
    end
  end

  // f2: parabolic faces
  logic signed [FW-1:0] f2_c, f2_l, f2_r, f2_bl, f2_br;
  logic signed [FW-1:0] w1, w2, w3, sd1, sd2, sd3;

  always_comb begin
    w1  = FW'(f1_y1);
    w2  = FW'(f1_y2);
    w3  = FW'(f1_y3);
    sd1 = FW'(f1_sl[0]);
    sd2 = FW'(f1_sl[1]);
    sd3 = FW'(f1_sl[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_c  <= (w2 <<< 3) + (w2 <<< 2);
      f2_bl <= (w1 <<< 3) + (w1 <<< 2);
      f2_br <= (w3 <<< 3) + (w3 <<< 2);
      f2_l  <= ((w1 + w2) <<< 2) + ((w1 + w2) <<< 1) - (sd2 - sd1);
      f2_r  <= ((w2 + w3) <<< 2) + ((w2 + w3) <<< 1) - (sd3 - sd2);
    end
  end

  // f3: clip between neighbors
  logic signed [FW-1:0] f3_c, f3_l, f3_r;
  logic signed [FW-1:0] llo, lhi, rlo, rhi, lc, rc;

  always_comb begin
    llo = (f2_c < f2_bl) ? f2_c : f2_bl;
    lhi = (f2_c > f2_bl) ? f2_c : f2_bl;
    rlo = (f2_c < f2_br) ? f2_c : f2_br;
    rhi = (f2_c > f2_br) ? f2_c : f2_br;
    lc  = (f2_l > llo) ? f2_l : llo;
    lc  = (lc < lhi) ? lc : lhi;
    rc  = (f2_r > rlo) ? f2_r : rlo;
    rc  = (rc < rhi) ? rc : rhi;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f3_c <= f2_c;
      f3_l <= lc;
      f3_r <= rc;
    end
  end

  // f4: monotonicity terms
  logic signed [FW-1:0] f4_c, f4_l, f4_r, f4_qd, f4_qe;

  always_ff @(posedge clk) begin
    if (adv) begin
      f4_c  <= f3_c;
      f4_l  <= f3_l;
      f4_r  <= f3_r;
      f4_qd <= f3_r - f3_l;
      f4_qe <= ((f3_c <<< 2) + (f3_c <<< 1)) - ((f3_l <<< 1) + f3_l)
               - ((f3_r <<< 1) + f3_r);
    end
  end

  // f5: extremum and steep-gradient rules
  logic signed [FW-1:0] f5_v [2];
  logic signed [FW-1:0] a_rc, a_cl, a_m, a_p, c3;
  logic                 ext, stl, str;

  always_comb begin
    a_rc = f4_r - f4_c;
    a_cl = f4_c - f4_l;
    a_m  = f4_qd - f4_qe;
    a_p  = f4_qd + f4_qe;
    c3   = (f4_c <<< 1) + f4_c;
    ext  = !((a_rc > 0 && a_cl > 0) || (a_rc < 0 && a_cl < 0));
    stl  = (f4_qd > 0 && a_m < 0) || (f4_qd < 0 && a_m > 0);
    str  = (f4_qd > 0 && a_p < 0) || (f4_qd < 0 && a_p > 0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (ext) begin
        f5_v[0] <= f4_c;
        f5_v[1] <= f4_c;
      end else if (stl) begin
        f5_v[0] <= c3 - (f4_r <<< 1);
        f5_v[1] <= f4_r;
      end else if (str) begin
        f5_v[0] <= f4_l;
        f5_v[1] <= c3 - (f4_l <<< 1);
      end else begin
        f5_v[0] <= f4_l;
        f5_v[1] <= f4_r;
      end
    end
  end

  // f6, f7, output: round to Q16.16 via floor((v + 6) / 12), saturate
  localparam logic signed [FW-1:0] X_HI = FW'(64'sd6442450944);   // 3 * 2^31
  localparam logic signed [FW-1:0] X_LO = -FW'(64'sd6442450944);

  logic [15:0] f6_qh [2];
  logic [16:0] f6_hi [2];
  logic [16:0] f6_lo [2];
  logic        f6_sh [2];
  logic        f6_sl [2];
  logic [15:0] f7_qh [2];
  logic [16:0] f7_ql [2];
  logic        f7_sh [2];
  logic        f7_sl [2];

  logic signed [FW-1:0] tx [2];
  logic signed [FW-1:0] xo [2];
  logic [36:0]          ph [2];
  logic [1:0]           rh [2];
  logic [38:0]          pl [2];
  logic [32:0]          uq [2];
  logic signed [DW-1:0] res [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      tx[j] = (f5_v[j] + FW'(6)) >>> 2;
      xo[j] = tx[j] - X_LO;
      ph[j] = 37'(xo[j][33:17]) * 37'(RECIP3);
      rh[j] = 2'(f6_hi[j] - 17'(3 * 17'(f6_qh[j])));
      pl[j] = 39'({rh[j], f6_lo[j]}) * 39'(RECIP3);
      uq[j] = {f7_qh[j], 17'd0} + 33'(f7_ql[j]);
      if (f7_sh[j]) begin
        res[j] = {1'b0, {(DW-1){1'b1}}};
      end else if (f7_sl[j]) begin
        res[j] = {1'b1, {(DW-1){1'b0}}};
      end else begin
        res[j] = {~uq[j][DW-1], uq[j][DW-2:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        f6_qh[j] <= ph[j][36:21];
        f6_hi[j] <= xo[j][33:17];
        f6_lo[j] <= xo[j][16:0];
        f6_sh[j] <= tx[j] >= X_HI;
        f6_sl[j] <= tx[j] < X_LO;
        f7_qh[j] <= f6_qh[j];
        f7_ql[j] <= pl[j][37:21];
        f7_sh[j] <= f6_sh[j];
        f7_sl[j] <= f6_sl[j];
      end
      left_face  <= res[0];
      right_face <= res[1];
    end
  end

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for ppm_face_reconstruct_top: directed and random stencils
// under all limiter modes, with random idling and a long output stall.
// Depends on ppmfr_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;
  import ppmfr_pkg::*;

  typedef struct packed {
    logic signed [31:0] left_face;
    logic signed [31:0] right_face;
  } faces_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_data = 2'd0;
  logic cfg_ready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] zone_minus2 = '0, zone_minus1 = '0, zone_centre = '0;
  logic signed [31:0] zone_plus1 = '0, zone_plus2 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] left_face, right_face;

  ppm_face_reconstruct_top uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .zone_minus2(zone_minus2), .zone_minus1(zone_minus1), .zone_centre(zone_centre),
    .zone_plus1(zone_plus1), .zone_plus2(zone_plus2),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_face(left_face), .right_face(right_face)
  );

  lim_mode_t mode_shadow = LIM_MC;
  faces_t face_queue[$];
  int errors = 0;
  int checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  longint cycle_count = 0;

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  function automatic longint lim_slope(longint a, longint b, longint c);
    longint d1, d2, dc, m1, m2, mag, u1, u2, p, s, q, rm;
    d1 = b - a; d2 = c - b; dc = c - a;
    if (mode_shadow == LIM_NONE) return dc;
    if (!((d1 > 0 && d2 > 0) || (d1 < 0 && d2 < 0))) return 0;
    u1 = d1 < 0 ? -d1 : d1;
    u2 = d2 < 0 ? -d2 : d2;
    m1 = 4 * u1; m2 = 4 * u2;
    if (mode_shadow == LIM_VANLEER) begin
      p = u1 * u2; s = u1 + u2;
      q = p / s; rm = p % s;
      mag = 8 * q + (8 * rm) / s;
    end else if (mode_shadow == LIM_MC) begin
      mag = dc < 0 ? -dc : dc;
      if (m1 < mag) mag = m1;
      if (m2 < mag) mag = m2;
    end else begin
      mag = m1 < m2 ? m1 : m2;
    end
    return dc < 0 ? -mag : mag;
  endfunction

  function automatic logic signed [31:0] round_sat(longint v);
    longint t, q;
    t = v + 6;
    q = t / 12;
    if (t % 12 != 0 && t < 0) q -= 1;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic int sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic faces_t predict_faces(logic signed [31:0] z0, z1, z2, z3, z4);
    longint y0, y1, y2, y3, y4, s1, s2, s3, c, l, r, qd, qe, lo, hi;
    faces_t f;
    y0 = z0; y1 = z1; y2 = z2; y3 = z3; y4 = z4;
    s1 = lim_slope(y0, y1, y2);
    s2 = lim_slope(y1, y2, y3);
    s3 = lim_slope(y2, y3, y4);
    c = 12 * y2;
    l = 6 * (y1 + y2) - (s2 - s1);
    r = 6 * (y2 + y3) - (s3 - s2);
    lo = c < 12 * y1 ? c : 12 * y1; hi = c > 12 * y1 ? c : 12 * y1;
    if (l < lo) l = lo;
    if (l > hi) l = hi;
    lo = c < 12 * y3 ? c : 12 * y3; hi = c > 12 * y3 ? c : 12 * y3;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    qd = r - l;
    qe = 6 * c - 3 * l - 3 * r;
    if (sgn(r - c) * sgn(c - l) <= 0) begin
      l = c; r = c;
    end else if (sgn(qd) * sgn(qd - qe) < 0) begin
      l = 3 * c - 2 * r;
    end else if (sgn(qd) * sgn(qd + qe) < 0) begin
      r = 3 * c - 2 * l;
    end
    f.left_face = round_sat(l);
    f.right_face = round_sat(r);
    return f;
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got, exp_v);
    errors++;
    $display("mismatch %s: got %0d expected %0d (mode %0d)", what, got, exp_v, mode_shadow);
  endtask

  always @(posedge clk) begin
    faces_t e;
    if (!rst && out_valid && out_ready) begin
      if (face_queue.size() == 0) begin
        report_mismatch("unexpected result left_face", left_face, 0);
      end else begin
        e = face_queue.pop_front();
        checked++;
        if (left_face !== e.left_face) report_mismatch("left_face", left_face, e.left_face);
        if (right_face !== e.right_face) report_mismatch("right_face", right_face, e.right_face);
      end
    end
  end

  always @(posedge clk) begin
    if (stall_cycles > 0) begin
      out_ready <= 1'b0;
      stall_cycles <= stall_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_stencil(logic signed [31:0] z0, z1, z2, z3, z4);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    zone_minus2 <= z0; zone_minus1 <= z1; zone_centre <= z2;
    zone_plus1 <= z3; zone_plus2 <= z4;
    face_queue.push_back(predict_faces(z0, z1, z2, z3, z4));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (face_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_mode(lim_mode_t m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_shadow = m;
  endtask

  function automatic logic signed [31:0] rand_zone();
    case ($urandom_range(3))
      0: rand_zone = $urandom;
      1: rand_zone = $signed($urandom_range(2000)) - 1000;
      2: rand_zone = $signed(32'($urandom_range(255)) << 16) - 32'sh0080_0000;
      default: rand_zone = $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(50)
                                               : 32'sh8000_0000 + $urandom_range(50);
    endcase
  endfunction

  task automatic send_random;
    logic signed [31:0] z[5];
    logic signed [31:0] step;
    int kind;
    kind = $urandom_range(9);
    if (kind < 6) begin
      z[0] = rand_zone();
      step = $signed($urandom_range(65536 * 4)) - 65536 * 2;
      for (int i = 1; i < 5; i++)
        z[i] = z[i-1] + step + $signed($urandom_range(40000)) - 20000;
    end else begin
      for (int i = 0; i < 5; i++) z[i] = rand_zone();
    end
    send_stencil(z[0], z[1], z[2], z[3], z[4]);
  endtask

  task automatic test_directed;
    send_stencil(0, 0, 0, 0, 0);
    send_stencil(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_stencil(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_stencil(32'sh8000_0000, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_stencil(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh8000_0000);
    send_stencil(0, 65536, 131072, 196608, 262144);
    send_stencil(0, 65536, 262144, 196608, 0);
    send_stencil(0, 65536, 0, 65536, 0);
    send_stencil(0, 0, 65536, 65536, 65536);
    send_stencil(0, 10, 20, 900000, 900010);
    send_stencil(0, 900000, 900010, 900020, 900030);
    send_stencil(-5, -3, 7, 100, 101);
    send_stencil(32'sh8000_0000, 32'sh8000_0001, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_stencil(32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001, 32'sh7FFF_0000);
  endtask

  task automatic test_all_modes;
    lim_mode_t modes[4] = '{LIM_VANLEER, LIM_MC, LIM_MINMOD, LIM_NONE};
    foreach (modes[m]) begin
      write_mode(modes[m]);
      test_directed();
    end
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    lim_mode_t modes[4] = '{LIM_VANLEER, LIM_MC, LIM_MINMOD, LIM_NONE};
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) write_mode(modes[$urandom_range(3)]);
      send_random();
    end
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_cycles = 300;
    for (int i = 0; i < 120; i++) send_random();
    drain();
    for (int i = 0; i < 20; i++) send_random();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_all_modes();
    test_random(500, 37, 69);
    test_random(500, 69, 37);
    test_random(500, 0, 0);
    test_backpressure();
    drain();
    $display("covered directed extremes in all limiter modes, %0d results checked,", checked);
    $display("random stencils under idling, a long output stall and mode changes");
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
